// ===== sv/ssst_pkg.sv =====
// Shared types for the sorted set span tracker.
// Holds the engine state encoding and the result record that the engine hands to the top level.
// Has no dependencies.
package ssst_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int CAP_W   = 7;
    localparam int OUT_W   = 80;   // 73 result bits rounded up to whole bytes

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_DONE
    } eng_state_t;

    typedef struct packed {
        logic                 spans_valid;
        logic [VALUE_W-1:0]   longest_span;
        logic [VALUE_W-1:0]   shortest_span;
        logic [COUNT_W-1:0]   entry_count;
        logic                 status;
    } result_t;

endpackage

// ===== sv/ssst_store.sv =====
// Value store of the sorted set span tracker: one write port, one read port.
// Read data is registered, so it appears in the cycle after the address.
// Depends on nothing but its parameters.
module ssst_store #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/ssst_engine.sv =====
// Insert engine of the sorted set span tracker: scans the store for the neighbours
// of a new value, updates the least gap and the extremes, and appends the value, or refuses it when full.
// Depends on ssst_pkg and ssst_store.
module ssst_engine
    import ssst_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] value,
    input  logic [CAP_W-1:0]   capacity,
    output logic               idle,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    eng_state_t         state_reg, state_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [VALUE_W-1:0] min_gap_reg, min_gap_next;
    logic [VALUE_W-1:0] min_val_reg, min_val_next;
    logic [VALUE_W-1:0] max_val_reg, max_val_next;
    logic [AW-1:0]      scan_idx_reg, scan_idx_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [VALUE_W-1:0] pred_reg, pred_next;
    logic               pred_found_reg, pred_found_next;
    logic [VALUE_W-1:0] succ_reg, succ_next;
    logic               succ_found_reg, succ_found_next;
    logic               status_reg, status_next;

    logic               full;
    logic               rd_en;
    logic               wr_en;
    logic [VALUE_W-1:0] rd_data;
    logic [VALUE_W-1:0] gap_lo;
    logic [VALUE_W-1:0] gap_hi;
    logic [VALUE_W-1:0] gap_step;

    // Full when the count reaches the programmed capacity or the store depth.
    assign full = (32'(count_reg) >= 32'(capacity)) || (32'(count_reg) >= 32'(MAX_ENTRIES));

    ssst_store #(
        .DEPTH  (MAX_ENTRIES),
        .DATA_W (VALUE_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (value_reg),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    assign gap_lo = value_reg - pred_reg;
    assign gap_hi = succ_reg - value_reg;

    always_comb
    begin
        gap_step = min_gap_reg;
        if (pred_found_reg && (gap_lo < gap_step))
        begin
            gap_step = gap_lo;
        end
        if (succ_found_reg && (gap_hi < gap_step))
        begin
            gap_step = gap_hi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            min_gap_reg    <= '1;
            rd_pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            min_gap_reg    <= min_gap_next;
            rd_pend_reg    <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        min_val_reg    <= min_val_next;
        max_val_reg    <= max_val_next;
        scan_idx_reg   <= scan_idx_next;
        pred_reg       <= pred_next;
        pred_found_reg <= pred_found_next;
        succ_reg       <= succ_next;
        succ_found_reg <= succ_found_next;
        status_reg     <= status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        value_next      = value_reg;
        count_next      = count_reg;
        min_gap_next    = min_gap_reg;
        min_val_next    = min_val_reg;
        max_val_next    = max_val_reg;
        scan_idx_next   = scan_idx_reg;
        pred_next       = pred_reg;
        pred_found_next = pred_found_reg;
        succ_next       = succ_reg;
        succ_found_next = succ_found_reg;
        status_next     = status_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        idle            = 1'b0;
        res_valid       = 1'b0;
        rd_pend_next    = (state_reg == ST_SCAN);

        // Fold each returning entry into the predecessor and successor candidates.
        if (rd_pend_reg)
        begin
            if (rd_data <= value_reg)
            begin
                if (!pred_found_reg || (rd_data > pred_reg))
                begin
                    pred_next       = rd_data;
                    pred_found_next = 1'b1;
                end
            end
            else if (!succ_found_reg || (rd_data < succ_reg))
            begin
                succ_next       = rd_data;
                succ_found_next = 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    value_next      = value;
                    scan_idx_next   = '0;
                    pred_found_next = 1'b0;
                    succ_found_next = 1'b0;
                    status_next     = full;
                    if (full)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_en = 1'b1;
                if (scan_idx_reg == AW'(count_reg - CW'(1)))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                wr_en        = 1'b1;
                count_next   = count_reg + CW'(1);
                min_gap_next = gap_step;
                if ((count_reg == '0) || (value_reg < min_val_reg))
                begin
                    min_val_next = value_reg;
                end
                if ((count_reg == '0) || (value_reg > max_val_reg))
                begin
                    max_val_next = value_reg;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status      = status_reg;
        res.entry_count = COUNT_W'(count_reg);
        res.spans_valid = (count_reg > CW'(1));
        if (count_reg > CW'(1))
        begin
            res.shortest_span = min_gap_reg;
            res.longest_span  = max_val_reg - min_val_reg;
        end
        else
        begin
            res.shortest_span = '0;
            res.longest_span  = '0;
        end
    end

endmodule

// ===== sv/sorted_set_span_tracker_unit.sv =====
// Sorted set span tracker: takes one 32-bit unsigned value per input transfer, adds it to
// the held set unless the set has reached its capacity, and returns one result transfer with
// the insert status, the count held, the least difference between sorted neighbours and
// the difference between the largest and smallest values held. Values live in a single-port-
// read store; an insert reads every held entry once to find the new value's neighbours.
// An accepted value passes through the reads of the held entries, a wait for the last
// read to return, a write-back that updates the gap and extremes, the engine presenting
// the result and the output register; a rejected value goes straight to presenting the
// result, and the first value skips the reads. One item is in the engine at a time; the
// result sits in an output register, and the engine is free for the next value as soon as
// the result has moved there. The store needs no clearing after reset: only entries below
// the count are ever read.
// Depends on ssst_pkg and ssst_engine.
module sorted_set_span_tracker_unit
    import ssst_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    // Capacity register write port
    input  logic               cfg_wr_en,
    input  logic [CAP_W-1:0]   cfg_wr_data,    // capacity
    // Input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,        // [31:0] value
    // Result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata         // [0] status, [7:1] entry_count,
                                               // [39:8] shortest_span,
                                               // [71:40] longest_span,
                                               // [72] spans_valid, [79:73] zero
);

    logic [CAP_W-1:0] capacity_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg;

    logic             eng_idle;
    logic             eng_res_valid;
    logic             eng_res_ready;
    result_t          eng_res;

    // Capacity register: written whenever the write enable is high.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_W'(64);
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // Accept a new value only while the engine has nothing in hand.
    assign s_tready = eng_idle;

    ssst_engine #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_tvalid && s_tready),
        .value     (s_tdata),
        .capacity  (capacity_reg),
        .idle      (eng_idle),
        .res_valid (eng_res_valid),
        .res_ready (eng_res_ready),
        .res       (eng_res)
    );

    // Output register: take a new result when empty or when the current one leaves.
    assign eng_res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (eng_res_valid && eng_res_ready)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Hold the payload while a result waits; load a fresh one on each engine transfer.
    always_ff @(posedge clk)
    begin
        if (eng_res_valid && eng_res_ready)
        begin
            m_tdata_reg <= OUT_W'(eng_res);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/ssst_checker.sv =====
// Port-level checks for the sorted set span tracker, attached to the top level by bind.
// Depends on ssst_pkg.
module ssst_checker
    import ssst_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [OUT_W-1:0]   m_tdata
);

    // Hold a stalled result unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Drop ready after an input transfer: one value is worked on at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while engine busy");

    // Spans are flagged valid exactly when two or more values are held.
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[72] == (m_tdata[7:1] > 7'd1)))
        else $error("spans_valid disagrees with entry_count");

    // Zero both spans while they are not valid.
    a_spans_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[72] |-> (m_tdata[71:8] == 64'd0))
        else $error("spans not zero while invalid");

endmodule

bind sorted_set_span_tracker_unit ssst_checker u_ssst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_sorted_set_span_tracker_unit.sv =====
// Testbench for sorted_set_span_tracker_unit: drives values through the input stream,
// predicts every result from its own model of the sorted store and checks each result transfer.
// Depends on ssst_pkg and the RTL of sorted_set_span_tracker_unit.
`timescale 1ns / 100ps

module tb_sorted_set_span_tracker_unit;
    import ssst_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off for back-pressure
    localparam int SETTLE_CYCLES = 8;     // idle cycles before a capacity write
    localparam int TAIL_CYCLES = 80;      // above the worst insert latency

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;
    typedef enum logic [1:0] {VM_CLUSTER, VM_WIDE, VM_MIX} value_mode_t;
    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [VALUE_W-1:0] value;      // capacity for ROW_CFG rows
        logic               typed;      // expectation given in the row itself
        result_t            res;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [CAP_W-1:0]   cfg_wr_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;

    // Predictor state: held values in ascending order, count, least gap, capacity
    logic [VALUE_W-1:0] held_vals [STORE_DEPTH];
    int unsigned        held_n;
    logic [VALUE_W-1:0] gap_min;
    logic [CAP_W-1:0]   cap_reg;

    result_t            pending_results [$];
    dir_row_t           dir_table [$];

    // Sender burst shaping
    int unsigned        burst_left;
    bit                 gaps_on;

    // Receiver hold-off request, raised by the stimulus and cleared by the receiver
    bit                 hold_off_req;

    int unsigned        n_accepted;
    int unsigned        n_stored;
    int unsigned        n_refused;
    int unsigned        n_checked;
    int unsigned        n_cfg;
    int unsigned        n_errors;

    sorted_set_span_tracker_unit #(
        .MAX_ENTRIES (STORE_DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),        // [31:0] value
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)         // [0] status, [7:1] entry_count, [39:8] shortest_span,
                                       // [71:40] longest_span, [72] spans_valid, [79:73] zero
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous ceiling on the length of the run
    initial
    begin
        #5_000_000;
        $display("tb_sorted_set_span_tracker_unit: done, errors");
        $finish;
    end

    // Work out the result of one accepted value and advance the predictor state.
    function automatic result_t predict_span(input logic [VALUE_W-1:0] v);
        result_t            r;
        int unsigned        lim;
        int unsigned        pos;
        logic [VALUE_W-1:0] d;
        r   = '0;
        lim = (cap_reg > STORE_DEPTH) ? STORE_DEPTH : cap_reg;
        if (held_n >= lim || held_n >= STORE_DEPTH)
        begin
            r.status = 1'b1;
        end
        else
        begin
            // Find the first held value above v; equal values go after existing ones
            pos = 0;
            while (pos < held_n && held_vals[pos] <= v)
                pos++;
            // Only the gaps beside the new value can lower the minimum
            if (pos > 0)
            begin
                d = v - held_vals[pos-1];
                if (d < gap_min)
                    gap_min = d;
            end
            if (pos < held_n)
            begin
                d = held_vals[pos] - v;
                if (d < gap_min)
                    gap_min = d;
            end
            for (int i = held_n; i > pos; i--)
                held_vals[i] = held_vals[i-1];
            held_vals[pos] = v;
            held_n++;
        end
        r.entry_count = held_n[COUNT_W-1:0];
        if (held_n >= 2)
        begin
            r.spans_valid   = 1'b1;
            r.shortest_span = gap_min;
            r.longest_span  = held_vals[held_n-1] - held_vals[0];
        end
        return r;
    endfunction

    function automatic result_t mk_result(input logic st, input logic [COUNT_W-1:0] cnt,
                                          input logic [VALUE_W-1:0] shortest,
                                          input logic [VALUE_W-1:0] longest,
                                          input logic valid);
        result_t r;
        r.status        = st;
        r.entry_count   = cnt;
        r.shortest_span = shortest;
        r.longest_span  = longest;
        r.spans_valid   = valid;
        return r;
    endfunction

    function automatic void add_cfg(input logic [CAP_W-1:0] c);
        dir_row_t row;
        row       = '0;
        row.kind  = ROW_CFG;
        row.value = VALUE_W'(c);
        dir_table = {dir_table, row};
    endfunction

    function automatic void add_item(input logic [VALUE_W-1:0] v, input logic typed,
                                     input result_t res);
        dir_row_t row;
        row.kind  = ROW_ITEM;
        row.value = v;
        row.typed = typed;
        row.res   = res;
        dir_table = {dir_table, row};
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(input value_mode_t mode);
        logic [VALUE_W-1:0] v;
        case (mode)
            VM_CLUSTER:
                // Stay near mid-range so the least gap shrinks step by step
                v = 32'h8000_0000 - 32'h0008_0000 + VALUE_W'($urandom_range(0, 32'h000F_FFFF));
            VM_MIX:
                case ($urandom_range(0, 9))
                    0:       v = '0;
                    1:       v = '1;
                    2, 3:    v = (held_n > 0) ? held_vals[$urandom_range(0, held_n-1)]
                                              : VALUE_W'($urandom);
                    4:       v = (held_n > 0) ? held_vals[$urandom_range(0, held_n-1)] + 1
                                              : VALUE_W'($urandom);
                    default: v = VALUE_W'($urandom);
                endcase
            default:
                v = VALUE_W'($urandom);
        endcase
        return v;
    endfunction

    // Offer one value, in bursts with random gaps when gaps are on; return once the transfer has happened.
    task automatic send_value(input logic [VALUE_W-1:0] v, input logic typed,
                              input result_t res);
        result_t predicted;
        @(negedge clk);
        if (gaps_on && burst_left == 0)
        begin
            s_tvalid = 1'b0;
            s_tdata  = VALUE_W'($urandom);   // noise while idle, must be ignored
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid = 1'b1;
        s_tdata  = v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        predicted = predict_span(v);
        pending_results = {pending_results, (typed ? res : predicted)};
        n_accepted++;
        if (predicted.status)
            n_refused++;
        else
            n_stored++;
    endtask

    task automatic idle_input();
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Write the capacity only once every result is out and the engine has settled.
    task automatic write_capacity(input logic [CAP_W-1:0] c);
        idle_input();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = c;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        cfg_wr_data = CAP_W'($urandom);
        cap_reg     = c;
        n_cfg++;
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] c, input int unsigned count,
                             input value_mode_t mode, input bit with_gaps,
                             input bit with_hold);
        write_capacity(c);
        gaps_on = with_gaps;
        if (with_hold)
            hold_off_req = 1'b1;
        repeat (count)
            send_value(pick_value(mode), 1'b0, '0);
    endtask

    function automatic void report_field(input string name, input logic [VALUE_W-1:0] exp_v,
                                         input logic [VALUE_W-1:0] act_v);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
        n_errors++;
    endfunction

    // Result checker: compare every result transfer with the oldest expectation
    always @(posedge clk)
    begin
        result_t act;
        result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            act = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, actual 0x%0h",
                         $time, m_tdata);
                n_errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (act.status !== exp_r.status)
                    report_field("status", VALUE_W'(exp_r.status), VALUE_W'(act.status));
                if (act.entry_count !== exp_r.entry_count)
                    report_field("entry_count", VALUE_W'(exp_r.entry_count),
                                 VALUE_W'(act.entry_count));
                if (act.shortest_span !== exp_r.shortest_span)
                    report_field("shortest_span", exp_r.shortest_span, act.shortest_span);
                if (act.longest_span !== exp_r.longest_span)
                    report_field("longest_span", exp_r.longest_span, act.longest_span);
                if (act.spans_valid !== exp_r.spans_valid)
                    report_field("spans_valid", VALUE_W'(exp_r.spans_valid),
                                 VALUE_W'(act.spans_valid));
                if (m_tdata[OUT_W-1:$bits(result_t)] !== '0)
                    report_field("pad bits", '0,
                                 VALUE_W'(m_tdata[OUT_W-1:$bits(result_t)]));
            end
        end
    end

    // Receiver: switch between randomly chosen stall patterns; on request, hold off for a long stretch
    initial
    begin
        rx_mode_t    rx_mode;
        int unsigned mode_left;
        int unsigned held_for;
        int unsigned phase_cnt;
        m_tready  = 1'b0;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        phase_cnt = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                // Hold ready low while the sender keeps offering, so the block backs up
                m_tready = 1'b0;
                for (held_for = 1; held_for < HOLD_CYCLES; held_for++)
                    @(negedge clk);
                hold_off_req = 1'b0;
            end
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(64, 256);
            end
            mode_left--;
            phase_cnt++;
            case (rx_mode)
                RX_OPEN:   m_tready = 1'b1;
                RX_RANDOM: m_tready = 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
                default:   m_tready = phase_cnt[0];
            endcase
        end
    end

    // Stimulus: directed table first, then random phases over several capacities
    initial
    begin
        dir_row_t row;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        hold_off_req = 1'b0;
        gaps_on      = 1'b1;
        burst_left   = 0;
        held_n       = 0;
        gap_min      = '1;
        cap_reg      = CAP_W'(64);
        n_accepted   = 0;
        n_stored     = 0;
        n_refused    = 0;
        n_checked    = 0;
        n_cfg        = 0;
        n_errors     = 0;
        for (int i = 0; i < STORE_DEPTH; i++)
            held_vals[i] = '0;

        // First value under the reset capacity: one held, spans not yet valid
        add_item(32'h8000_0000, 1'b1, mk_result(1'b0, 7'd1, '0, '0, 1'b0));
        // Capacity of zero: refuse both extremes, count and spans unchanged
        add_cfg(CAP_W'(0));
        add_item(32'hFFFF_FFFF, 1'b1, mk_result(1'b1, 7'd1, '0, '0, 1'b0));
        add_item(32'h0000_0000, 1'b1, mk_result(1'b1, 7'd1, '0, '0, 1'b0));
        // Small capacity: two more fit, spans become valid, then the set is full
        add_cfg(CAP_W'(3));
        add_item(32'h8000_1000, 1'b1, mk_result(1'b0, 7'd2, 32'h1000, 32'h1000, 1'b1));
        add_item(32'h7FFF_F000, 1'b1, mk_result(1'b0, 7'd3, 32'h1000, 32'h2000, 1'b1));
        add_item(32'h0000_0000, 1'b1, mk_result(1'b1, 7'd3, 32'h1000, 32'h2000, 1'b1));
        // Capacity beyond the store: effective limit is the store depth
        add_cfg(CAP_W'(127));
        add_item(32'h8000_0800, 1'b0, '0);
        add_item(32'h8000_0801, 1'b0, '0);
        add_item(32'h7FFF_FFFF, 1'b0, '0);
        add_item(32'h5555_5555, 1'b0, '0);
        add_item(32'hAAAA_AAAA, 1'b0, '0);
        // Capacity lowered below the count: everything refused
        add_cfg(CAP_W'(4));
        add_item(32'h1234_5678, 1'b0, '0);
        add_item(32'hFFFF_FFFE, 1'b0, '0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_table[i])
        begin
            row = dir_table[i];
            if (row.kind == ROW_CFG)
                write_capacity(row.value[CAP_W-1:0]);
            else
                send_value(row.value, row.typed, row.res);
        end

        run_phase(CAP_W'(16),  100, VM_CLUSTER, 1'b1, 1'b0);
        run_phase(CAP_W'(8),    60, VM_WIDE,    1'b1, 1'b0);
        run_phase(CAP_W'(40),  130, VM_CLUSTER, 1'b1, 1'b1);
        run_phase(CAP_W'(64),  150, VM_MIX,     1'b0, 1'b0);
        run_phase(CAP_W'(127), 130, VM_WIDE,    1'b1, 1'b0);
        run_phase(CAP_W'(0),    60, VM_WIDE,    1'b0, 1'b0);
        run_phase(CAP_W'(100),  50, VM_MIX,     1'b1, 1'b0);

        // Drain, then watch a while longer for stray results
        idle_input();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d values (%0d stored, %0d refused) across %0d capacity writes",
                 n_accepted, n_stored, n_refused, n_cfg);
        $display("%0d results checked, store ended with %0d values", n_checked, held_n);
        if (n_errors == 0)
            $display("tb_sorted_set_span_tracker_unit: done, clean");
        else
            $display("tb_sorted_set_span_tracker_unit: done, errors");
        $finish;
    end

endmodule
